/* hdl/atfs_pkg.sv */
// shared types and constants for the ata task-file setup block
`timescale 1ns / 1ps

package atfs_pkg;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;
    localparam int ADDR_W     = 32;
    localparam int LBA28_W    = 28;
    localparam int QUOT_W     = 23;

    // reciprocal of 63 scaled by 2^34, exact for 28-bit dividends
    localparam logic [28:0] RECIP_63   = 29'd272696337;
    localparam int          RECIP_SHFT = 34;
    localparam int          PROD_W     = 57;

    localparam logic [7:0] SEL_CHS = 8'hA0;
    localparam logic [7:0] SEL_LBA = 8'hE0;
    localparam logic [7:0] CTL_HOB = 8'h80;
    localparam logic [7:0] CTL_NIEN = 8'h02;

    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] CMD_WRITE     = 8'h30;
    localparam logic [7:0] CMD_READ_EXT  = 8'h24;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

    localparam logic [1:0] CFG_CHANNEL = 2'd0;
    localparam logic [1:0] CFG_SLAVE   = 2'd1;
    localparam logic [1:0] CFG_LBA     = 2'd2;

    typedef enum logic [2:0] {
        TREG_CONTROL = 3'd0,
        TREG_SELECT  = 3'd1,
        TREG_COUNT   = 3'd2,
        TREG_LBA_LO  = 3'd3,
        TREG_LBA_MID = 3'd4,
        TREG_LBA_HI  = 3'd5,
        TREG_COMMAND = 3'd6
    } treg_t;

    // task-file bytes of one request
    typedef struct packed {
        logic       chan;
        logic       ext;
        logic [7:0] count;
        logic [7:0] sel;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] hob_lo;
        logic [7:0] cmd;
    } atfs_item_t;

endpackage

/* hdl/atfs_front.sv */
// request register, chs divide by 63 and task-file byte build
`timescale 1ns / 1ps

module atfs_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [3:0]                     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [atfs_pkg::IN_DATA_W-1:0] in_data,
    output logic                           item_valid,
    input  logic                           item_ready,
    output atfs_pkg::atfs_item_t           item
);
    import atfs_pkg::*;

    logic [3:0] chan_mask_reg;
    logic [3:0] slave_mask_reg;
    logic [3:0] lba_mask_reg;

    logic              s1_valid_reg;
    logic              s1_wr_reg;
    logic              s1_chan_reg;
    logic              s1_slave_reg;
    logic              s1_lba_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [7:0]        s1_count_reg;

    logic              s2_valid_reg;
    logic              s2_wr_reg;
    logic              s2_chan_reg;
    logic              s2_slave_reg;
    logic              s2_lba_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [7:0]        s2_count_reg;
    logic [QUOT_W-1:0] s2_quot_reg;

    logic              s1_ready;
    logic              s2_ready;
    logic [1:0]        in_drive;
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot_next;
    logic              ext;
    logic [5:0]        rem;
    logic [5:0]        sect;
    logic [3:0]        head;
    logic [15:0]       cyl;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_mask_reg  <= 4'd12;
            slave_mask_reg <= 4'd10;
            lba_mask_reg   <= 4'd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CHANNEL: chan_mask_reg  <= cfg_wdata;
                CFG_SLAVE:   slave_mask_reg <= cfg_wdata;
                CFG_LBA:     lba_mask_reg   <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    assign s2_ready = !s2_valid_reg || item_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;
    assign in_drive = in_data[2:1];

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_wr_reg    <= in_data[0];
            s1_chan_reg  <= chan_mask_reg[in_drive];
            s1_slave_reg <= slave_mask_reg[in_drive];
            s1_lba_reg   <= lba_mask_reg[in_drive];
            s1_addr_reg  <= in_data[34:3];
            s1_count_reg <= in_data[42:35];
        end
    end

    // quotient by 63 through the scaled reciprocal
    assign prod      = {{(PROD_W-LBA28_W){1'b0}}, s1_addr_reg[LBA28_W-1:0]}
                     * {{(PROD_W-29){1'b0}}, RECIP_63};
    assign quot_next = prod[PROD_W-1:RECIP_SHFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_wr_reg    <= s1_wr_reg;
            s2_chan_reg  <= s1_chan_reg;
            s2_slave_reg <= s1_slave_reg;
            s2_lba_reg   <= s1_lba_reg;
            s2_addr_reg  <= s1_addr_reg;
            s2_count_reg <= s1_count_reg;
            s2_quot_reg  <= quot_next;
        end
    end

    // remainder from low bits: addr - 63q == addr + q modulo 64
    assign rem  = s2_addr_reg[5:0] + s2_quot_reg[5:0];
    assign sect = rem + 6'd1;
    assign head = s2_quot_reg[3:0];
    assign cyl  = s2_quot_reg[19:4];
    assign ext  = (s2_addr_reg[31:28] != 4'd0);

    always_comb
    begin
        item.chan   = s2_chan_reg;
        item.ext    = ext;
        item.count  = s2_count_reg;
        item.hob_lo = s2_addr_reg[31:24];
        if (ext)
        begin
            item.sel = SEL_LBA | {3'b000, s2_slave_reg, 4'h0};
            item.b0  = s2_addr_reg[7:0];
            item.b1  = s2_addr_reg[15:8];
            item.b2  = s2_addr_reg[23:16];
            item.cmd = s2_wr_reg ? CMD_WRITE_EXT : CMD_READ_EXT;
        end
        else if (s2_lba_reg)
        begin
            item.sel = SEL_LBA | {3'b000, s2_slave_reg, s2_addr_reg[27:24]};
            item.b0  = s2_addr_reg[7:0];
            item.b1  = s2_addr_reg[15:8];
            item.b2  = s2_addr_reg[23:16];
            item.cmd = s2_wr_reg ? CMD_WRITE : CMD_READ;
        end
        else
        begin
            item.sel = SEL_CHS | {3'b000, s2_slave_reg, head};
            item.b0  = {2'b00, sect};
            item.b1  = cyl[7:0];
            item.b2  = cyl[15:8];
            item.cmd = s2_wr_reg ? CMD_WRITE : CMD_READ;
        end
    end

    assign item_valid = s2_valid_reg;

endmodule

/* hdl/atfs_sequencer.sv */
// steps through the task-file writes of one item into the output register
`timescale 1ns / 1ps

module atfs_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  atfs_pkg::atfs_item_t item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_chan,
    output logic [2:0]           out_treg,
    output logic [7:0]           out_value,
    output logic                 out_last
);
    import atfs_pkg::*;

    typedef enum logic [18:0] {
        ST_NIEN   = 19'h00001,
        ST_SEL    = 19'h00002,
        ST_HSET0  = 19'h00004,
        ST_HCNT   = 19'h00008,
        ST_HCLR0  = 19'h00010,
        ST_HSET1  = 19'h00020,
        ST_HLO    = 19'h00040,
        ST_HCLR1  = 19'h00080,
        ST_HSET2  = 19'h00100,
        ST_HMID   = 19'h00200,
        ST_HCLR2  = 19'h00400,
        ST_HSET3  = 19'h00800,
        ST_HHI    = 19'h01000,
        ST_HCLR3  = 19'h02000,
        ST_CNT    = 19'h04000,
        ST_LO     = 19'h08000,
        ST_MID    = 19'h10000,
        ST_HI     = 19'h20000,
        ST_CMD    = 19'h40000
    } step_t;

    step_t      step_reg;
    step_t      step_next;
    logic       busy_reg;
    atfs_item_t item_reg;

    logic       out_valid_reg;
    logic       out_chan_reg;
    treg_t      out_treg_reg;
    logic [7:0] out_value_reg;
    logic       out_last_reg;

    logic       out_load;
    logic       emit;
    logic       at_end;
    treg_t      wr_treg;
    logic [7:0] wr_value;

    assign out_load   = !out_valid_reg || out_ready;
    assign emit       = busy_reg && out_load;
    assign at_end     = (step_reg == ST_CMD);
    assign item_ready = !busy_reg || (emit && at_end);

    // write of the current step
    always_comb
    begin
        step_next = step_t'({step_reg[17:0], 1'b0});
        wr_treg   = TREG_CONTROL;
        wr_value  = CTL_NIEN;
        unique case (step_reg) inside
            ST_NIEN, ST_HCLR0, ST_HCLR1, ST_HCLR2, ST_HCLR3:
            begin
                wr_treg  = TREG_CONTROL;
                wr_value = CTL_NIEN;
            end
            ST_SEL:
            begin
                wr_treg   = TREG_SELECT;
                wr_value  = item_reg.sel;
                step_next = item_reg.ext ? ST_HSET0 : ST_CNT;
            end
            ST_HSET0, ST_HSET1, ST_HSET2, ST_HSET3:
            begin
                wr_treg  = TREG_CONTROL;
                wr_value = CTL_HOB | CTL_NIEN;
            end
            ST_HCNT:
            begin
                wr_treg  = TREG_COUNT;
                wr_value = 8'h00;
            end
            ST_HLO:
            begin
                wr_treg  = TREG_LBA_LO;
                wr_value = item_reg.hob_lo;
            end
            ST_HMID:
            begin
                wr_treg  = TREG_LBA_MID;
                wr_value = 8'h00;
            end
            ST_HHI:
            begin
                wr_treg  = TREG_LBA_HI;
                wr_value = 8'h00;
            end
            ST_CNT:
            begin
                wr_treg  = TREG_COUNT;
                wr_value = item_reg.count;
            end
            ST_LO:
            begin
                wr_treg  = TREG_LBA_LO;
                wr_value = item_reg.b0;
            end
            ST_MID:
            begin
                wr_treg  = TREG_LBA_MID;
                wr_value = item_reg.b1;
            end
            ST_HI:
            begin
                wr_treg  = TREG_LBA_HI;
                wr_value = item_reg.b2;
            end
            ST_CMD:
            begin
                wr_treg   = TREG_COMMAND;
                wr_value  = item_reg.cmd;
                step_next = ST_NIEN;
            end
            default:
            begin
                step_next = ST_NIEN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= ST_NIEN;
        end
        else if (item_valid && item_ready)
        begin
            busy_reg <= 1'b1;
            step_reg <= ST_NIEN;
        end
        else if (emit)
        begin
            busy_reg <= !at_end;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_chan_reg  <= item_reg.chan;
            out_treg_reg  <= wr_treg;
            out_value_reg <= wr_value;
            out_last_reg  <= at_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_chan  = out_chan_reg;
    assign out_treg  = out_treg_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

/* hdl/ata_task_file_setup_core.sv */
// top level of the ata pio task-file setup block
//
// channel   dir  handshake              payload
// cfg       in   cfg_wr_en              cfg_index, cfg_wdata
// s_axis    in   tvalid / tready        tdata: request
// m_axis    out  tvalid / tready        tdata: register write, tlast: command write
//
// a request gives 7 writes (chs, lba28) or 19 writes (lba48), one per cycle unless
// m_axis stalls; the sequencer keeps each request until its command write
// first write shows after the divide reg, item reg and output reg
// two requests can wait in the front stages while the sequencer is busy
// reset clears all valid flags; config masks reset to 12, 10 and 0
`timescale 1ns / 1ps

module ata_task_file_setup_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[0], drive_number[2:1], block_address[34:3], sector_count[42:35], zeros
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bus_channel[0], target_register[3:1], write_value[11:4], zeros
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import atfs_pkg::*;

    logic       item_valid;
    logic       item_ready;
    atfs_item_t item;
    logic       out_chan;
    logic [2:0] out_treg;
    logic [7:0] out_value;

    atfs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    atfs_sequencer u_sequencer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_chan   (out_chan),
        .out_treg   (out_treg),
        .out_value  (out_value),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'h0, out_value, out_treg, out_chan};

endmodule
